### sv/mwmc_pkg.sv
// ----------------------------------------------------------------------------
// mwmc_pkg: shared types and constants for the minimum window cover block
// Holds the symbol and count widths, the opcode values, the sequencer step
// labels, the control word layout and the control program itself.
// ----------------------------------------------------------------------------
package mwmc_pkg;

    // Field widths and alphabet size.
    localparam int OPC_W     = 2;
    localparam int SYM_W     = 6;
    localparam int ALPHABET  = 52;
    localparam int CNT_W     = 13;
    localparam int SAT_W     = 6;
    localparam int POS_OUT_W = 12;

    // Pattern counts and the pattern length saturate at this value.
    localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

    // Input opcodes (value 3 is unused and ignored).
    typedef enum logic [OPC_W-1:0] {
        OPC_LOAD    = 2'd0,
        OPC_APPEND  = 2'd1,
        OPC_COMPUTE = 2'd2
    } opcode_t;

    // Program counter and step labels.
    typedef logic [4:0] step_t;

    localparam step_t S_IDLE        = 5'd0;
    localparam step_t S_DISP_LOAD   = 5'd1;
    localparam step_t S_DISP_APPEND = 5'd2;
    localparam step_t S_DISP_OTHER  = 5'd3;
    localparam step_t S_INIT        = 5'd4;
    localparam step_t S_TAIL_RD     = 5'd5;
    localparam step_t S_TAIL_CNT    = 5'd6;
    localparam step_t S_TAIL_UPD    = 5'd7;
    localparam step_t S_HEAD_RD     = 5'd8;
    localparam step_t S_HEAD_CNT    = 5'd9;
    localparam step_t S_HEAD_UPD    = 5'd10;
    localparam step_t S_BEST        = 5'd11;
    localparam step_t S_LOOP        = 5'd12;
    localparam step_t S_EMIT        = 5'd13;
    localparam step_t S_DONE        = 5'd14;
    localparam step_t S_LOAD_RD     = 5'd15;
    localparam step_t S_LOAD_WR     = 5'd16;
    localparam step_t S_APPEND      = 5'd17;

    // Jump conditions. When the condition holds the step counter loads the
    // target, otherwise it falls through to the next step.
    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_LOAD_OK,
        COND_APPEND_OK,
        COND_NOT_COMPUTE,
        COND_NO_PATTERN,
        COND_TEXT_END,
        COND_NOT_COVERED,
        COND_NOT_DROP,
        COND_STOP,
        COND_OUT_BUSY
    } cond_t;

    // Datapath actions, one per step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_REQ_READ,
        OP_PAT_INC,
        OP_TEXT_APPEND,
        OP_INIT,
        OP_TAIL_READ,
        OP_HEAD_READ,
        OP_COUNT_READ,
        OP_TAIL_UPD,
        OP_HEAD_UPD,
        OP_BEST,
        OP_EMIT
    } dp_op_t;

    // One control word of the program.
    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        step_t  target;
        logic   in_ready;
    } ctrl_t;

    // Status flags from the datapath that the jump conditions test.
    typedef struct packed {
        logic load_ok;
        logic append_ok;
        logic not_compute;
        logic no_pattern;
        logic text_end;
        logic not_covered;
        logic not_drop;
        logic stop;
        logic out_busy;
    } dp_status_t;

    // Control program. The compute item runs the tail loop (read text, read
    // counts, update) until the window covers the pattern, then the head
    // loop until one pattern symbol drops below its need, then a best check.
    function automatic ctrl_t ctrl_rom(input step_t step);
        ctrl_t word;
        word = '{op: OP_NONE, cond: COND_ALWAYS, target: S_IDLE, in_ready: 1'b0};
        unique case (step)
            S_IDLE:        word = '{op: OP_ACCEPT, cond: COND_NO_INPUT,
                                    target: S_IDLE, in_ready: 1'b1};
            S_DISP_LOAD:   word = '{op: OP_NONE, cond: COND_LOAD_OK,
                                    target: S_LOAD_RD, in_ready: 1'b0};
            S_DISP_APPEND: word = '{op: OP_NONE, cond: COND_APPEND_OK,
                                    target: S_APPEND, in_ready: 1'b0};
            S_DISP_OTHER:  word = '{op: OP_NONE, cond: COND_NOT_COMPUTE,
                                    target: S_IDLE, in_ready: 1'b0};
            S_INIT:        word = '{op: OP_INIT, cond: COND_NO_PATTERN,
                                    target: S_EMIT, in_ready: 1'b0};
            S_TAIL_RD:     word = '{op: OP_TAIL_READ, cond: COND_TEXT_END,
                                    target: S_EMIT, in_ready: 1'b0};
            S_TAIL_CNT:    word = '{op: OP_COUNT_READ, cond: COND_NEXT,
                                    target: S_IDLE, in_ready: 1'b0};
            S_TAIL_UPD:    word = '{op: OP_TAIL_UPD, cond: COND_NOT_COVERED,
                                    target: S_TAIL_RD, in_ready: 1'b0};
            S_HEAD_RD:     word = '{op: OP_HEAD_READ, cond: COND_NEXT,
                                    target: S_IDLE, in_ready: 1'b0};
            S_HEAD_CNT:    word = '{op: OP_COUNT_READ, cond: COND_NEXT,
                                    target: S_IDLE, in_ready: 1'b0};
            S_HEAD_UPD:    word = '{op: OP_HEAD_UPD, cond: COND_NOT_DROP,
                                    target: S_HEAD_RD, in_ready: 1'b0};
            S_BEST:        word = '{op: OP_BEST, cond: COND_STOP,
                                    target: S_EMIT, in_ready: 1'b0};
            S_LOOP:        word = '{op: OP_NONE, cond: COND_ALWAYS,
                                    target: S_TAIL_RD, in_ready: 1'b0};
            S_EMIT:        word = '{op: OP_EMIT, cond: COND_OUT_BUSY,
                                    target: S_EMIT, in_ready: 1'b0};
            S_DONE:        word = '{op: OP_NONE, cond: COND_ALWAYS,
                                    target: S_IDLE, in_ready: 1'b0};
            S_LOAD_RD:     word = '{op: OP_REQ_READ, cond: COND_NEXT,
                                    target: S_IDLE, in_ready: 1'b0};
            S_LOAD_WR:     word = '{op: OP_PAT_INC, cond: COND_ALWAYS,
                                    target: S_IDLE, in_ready: 1'b0};
            S_APPEND:      word = '{op: OP_TEXT_APPEND, cond: COND_ALWAYS,
                                    target: S_IDLE, in_ready: 1'b0};
            default:       word = '{op: OP_NONE, cond: COND_ALWAYS,
                                    target: S_IDLE, in_ready: 1'b0};
        endcase
        return word;
    endfunction

endpackage

### sv/mwmc_seq.sv
// ----------------------------------------------------------------------------
// mwmc_seq: microcode sequencer
// Steps through the control program, tests one jump condition per step and
// hands the current datapath action to the datapath.
// ----------------------------------------------------------------------------
module mwmc_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  mwmc_pkg::dp_status_t   status,
    output mwmc_pkg::dp_op_t       op,
    output logic                   in_ready
);

    mwmc_pkg::step_t step_reg;
    mwmc_pkg::step_t step_next;
    mwmc_pkg::ctrl_t ctrl;
    logic            jump;

    // Fetch the control word of the current step.
    assign ctrl     = mwmc_pkg::ctrl_rom(step_reg);
    assign op       = ctrl.op;
    assign in_ready = ctrl.in_ready;

    // Evaluate the jump condition.
    always_comb begin
        case (ctrl.cond)
            mwmc_pkg::COND_NEXT:        jump = 1'b0;
            mwmc_pkg::COND_ALWAYS:      jump = 1'b1;
            mwmc_pkg::COND_NO_INPUT:    jump = !s_tvalid;
            mwmc_pkg::COND_LOAD_OK:     jump = status.load_ok;
            mwmc_pkg::COND_APPEND_OK:   jump = status.append_ok;
            mwmc_pkg::COND_NOT_COMPUTE: jump = status.not_compute;
            mwmc_pkg::COND_NO_PATTERN:  jump = status.no_pattern;
            mwmc_pkg::COND_TEXT_END:    jump = status.text_end;
            mwmc_pkg::COND_NOT_COVERED: jump = status.not_covered;
            mwmc_pkg::COND_NOT_DROP:    jump = status.not_drop;
            mwmc_pkg::COND_STOP:        jump = status.stop;
            mwmc_pkg::COND_OUT_BUSY:    jump = status.out_busy;
            default:                    jump = 1'b1;
        endcase
    end

    assign step_next = jump ? ctrl.target : step_reg + 5'd1;

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= mwmc_pkg::S_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

### sv/mwmc_dp.sv
// ----------------------------------------------------------------------------
// mwmc_dp: datapath of the minimum window cover block
// Text store, pattern and window count tables, scan pointers, best window
// registers and the output register. Each step of the sequencer selects one
// action; the datapath reports the flags that the program branches on.
// ----------------------------------------------------------------------------
module mwmc_dp #(
    parameter int MAX_TEXT = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mwmc_pkg::dp_op_t       op,
    input  logic [1:0]             s_tuser,
    input  logic [7:0]             s_tdata,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic                   m_tuser,
    output logic [23:0]            m_tdata,
    output mwmc_pkg::dp_status_t   status
);

    localparam int LEN_W  = $clog2(MAX_TEXT + 1);
    localparam int ADDR_W = $clog2(MAX_TEXT);
    localparam int WIN_W  = (LEN_W > mwmc_pkg::CNT_W) ? LEN_W : mwmc_pkg::CNT_W;

    localparam int SYM_W = mwmc_pkg::SYM_W;
    localparam int CNT_W = mwmc_pkg::CNT_W;
    localparam int SAT_W = mwmc_pkg::SAT_W;
    localparam int POS_W = mwmc_pkg::POS_OUT_W;

    // Storage.
    logic [SYM_W-1:0] text_mem [0:MAX_TEXT-1];
    logic [CNT_W-1:0] req_mem  [0:mwmc_pkg::ALPHABET-1];
    logic [WIN_W-1:0] win_mem  [0:mwmc_pkg::ALPHABET-1];

    logic [mwmc_pkg::ALPHABET-1:0] req_valid_reg;
    logic [mwmc_pkg::ALPHABET-1:0] win_valid_reg;

    // Read data registers.
    logic [SYM_W-1:0] text_rdata_reg;
    logic [CNT_W-1:0] req_rdata_reg;
    logic [WIN_W-1:0] win_rdata_reg;
    logic             req_rvalid_reg;
    logic             win_rvalid_reg;

    // Control and payload registers.
    logic [1:0]       op_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [LEN_W-1:0] text_len_reg;
    logic [CNT_W-1:0] pat_len_reg;
    logic [SAT_W-1:0] distinct_reg;
    logic [SAT_W-1:0] sat_reg;
    logic [LEN_W-1:0] tcur_reg;
    logic [LEN_W-1:0] hcur_reg;
    logic [LEN_W-1:0] best_len_reg;
    logic [POS_W-1:0] best_start_reg;
    logic [POS_W-1:0] best_end_reg;
    logic             found_reg;
    logic             m_tvalid_reg;
    logic             m_found_reg;
    logic [POS_W-1:0] m_start_reg;
    logic [POS_W-1:0] m_end_reg;

    // Combinational helpers.
    logic [ADDR_W-1:0] text_raddr;
    logic [SYM_W-1:0]  cnt_raddr;
    logic [CNT_W-1:0]  req_val;
    logic [WIN_W-1:0]  win_val;
    logic [WIN_W-1:0]  req_wide;
    logic [CNT_W-1:0]  req_inc;
    logic [WIN_W-1:0]  tail_cnt;
    logic [WIN_W-1:0]  head_cnt;
    logic              tail_match;
    logic              covered;
    logic              drop;
    logic [LEN_W-1:0]  diff;
    logic              improved;
    logic              stop;
    logic              sym_ok;
    logic              out_busy;
    logic              emit_fire;

    // Read address selection.
    assign text_raddr = (op == mwmc_pkg::OP_HEAD_READ) ? hcur_reg[ADDR_W-1:0]
                                                       : tcur_reg[ADDR_W-1:0];
    assign cnt_raddr  = (op == mwmc_pkg::OP_COUNT_READ) ? text_rdata_reg : sym_reg;

    // Entries that were never written since the last clear read as zero.
    assign req_val  = req_rvalid_reg ? req_rdata_reg : '0;
    assign win_val  = win_rvalid_reg ? win_rdata_reg : '0;
    assign req_wide = WIN_W'(req_val);
    assign req_inc  = (req_val == mwmc_pkg::CNT_MAX) ? req_val : req_val + CNT_W'(1);

    // Tail step: a symbol reaches its need; the window covers the pattern
    // when that was the last unsatisfied symbol.
    assign tail_cnt   = win_val + WIN_W'(1);
    assign tail_match = (tail_cnt == req_wide);
    assign covered    = tail_match && ((sat_reg + SAT_W'(1)) == distinct_reg);

    // Head step: removing this symbol takes it below its need.
    assign head_cnt = win_val - WIN_W'(1);
    assign drop     = (win_val == req_wide);

    // Best window check and early stop at pattern length.
    assign diff     = tcur_reg - hcur_reg;
    assign improved = (diff < best_len_reg);
    assign stop     = improved && ((32'(diff) + 32'd1) == 32'(pat_len_reg));

    assign sym_ok    = (sym_reg < SYM_W'(mwmc_pkg::ALPHABET));
    assign out_busy  = m_tvalid_reg && !m_tready;
    assign emit_fire = (op == mwmc_pkg::OP_EMIT) && !out_busy;

    // Status toward the sequencer.
    always_comb begin
        status.load_ok     = (op_reg == mwmc_pkg::OPC_LOAD) && sym_ok;
        status.append_ok   = (op_reg == mwmc_pkg::OPC_APPEND) && sym_ok
                             && (text_len_reg < LEN_W'(MAX_TEXT));
        status.not_compute = (op_reg != mwmc_pkg::OPC_COMPUTE);
        status.no_pattern  = (distinct_reg == '0);
        status.text_end    = (tcur_reg >= text_len_reg);
        status.not_covered = !covered;
        status.not_drop    = !drop;
        status.stop        = stop;
        status.out_busy    = out_busy;
    end

    // Text store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (op == mwmc_pkg::OP_TEXT_APPEND) begin
            text_mem[text_len_reg[ADDR_W-1:0]] <= sym_reg;
        end
        text_rdata_reg <= text_mem[text_raddr];
    end

    // Pattern count table.
    always_ff @(posedge aclk) begin
        if (op == mwmc_pkg::OP_PAT_INC) begin
            req_mem[sym_reg] <= req_inc;
        end
        req_rdata_reg  <= req_mem[cnt_raddr];
        req_rvalid_reg <= req_valid_reg[cnt_raddr];
    end

    // Window count table.
    always_ff @(posedge aclk) begin
        if (op == mwmc_pkg::OP_TAIL_UPD) begin
            win_mem[sym_reg] <= tail_cnt;
        end else if (op == mwmc_pkg::OP_HEAD_UPD) begin
            win_mem[sym_reg] <= head_cnt;
        end
        win_rdata_reg  <= win_mem[cnt_raddr];
        win_rvalid_reg <= win_valid_reg[cnt_raddr];
    end

    // Control state: lengths, counters, valid bits and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_len_reg  <= '0;
            pat_len_reg   <= '0;
            distinct_reg  <= '0;
            sat_reg       <= '0;
            found_reg     <= 1'b0;
            req_valid_reg <= '0;
            win_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // A new result replaces one that is taken in the same cycle.
            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (op)
                mwmc_pkg::OP_PAT_INC: begin
                    req_valid_reg[sym_reg] <= 1'b1;
                    if (!req_rvalid_reg) begin
                        distinct_reg <= distinct_reg + SAT_W'(1);
                    end
                    if (pat_len_reg != mwmc_pkg::CNT_MAX) begin
                        pat_len_reg <= pat_len_reg + CNT_W'(1);
                    end
                end
                mwmc_pkg::OP_TEXT_APPEND: begin
                    text_len_reg <= text_len_reg + LEN_W'(1);
                end
                mwmc_pkg::OP_INIT: begin
                    found_reg <= 1'b0;
                end
                mwmc_pkg::OP_TAIL_UPD: begin
                    win_valid_reg[sym_reg] <= 1'b1;
                    if (tail_match) begin
                        sat_reg <= sat_reg + SAT_W'(1);
                    end
                end
                mwmc_pkg::OP_HEAD_UPD: begin
                    win_valid_reg[sym_reg] <= 1'b1;
                    if (drop) begin
                        sat_reg <= sat_reg - SAT_W'(1);
                    end
                end
                mwmc_pkg::OP_BEST: begin
                    if (improved) begin
                        found_reg <= 1'b1;
                    end
                end
                mwmc_pkg::OP_EMIT: begin
                    // Hand the result over and return to the cleared state.
                    if (!out_busy) begin
                        text_len_reg  <= '0;
                        pat_len_reg   <= '0;
                        distinct_reg  <= '0;
                        sat_reg       <= '0;
                        req_valid_reg <= '0;
                        win_valid_reg <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload: input latch, scan pointers, best window and result fields.
    always_ff @(posedge aclk) begin
        case (op)
            mwmc_pkg::OP_ACCEPT: begin
                op_reg  <= s_tuser;
                sym_reg <= s_tdata[SYM_W-1:0];
            end
            mwmc_pkg::OP_COUNT_READ: begin
                sym_reg <= text_rdata_reg;
            end
            mwmc_pkg::OP_INIT: begin
                tcur_reg     <= '0;
                hcur_reg     <= '0;
                best_len_reg <= text_len_reg;
            end
            mwmc_pkg::OP_TAIL_UPD: begin
                // The cursor stays on the tail once the window covers.
                if (!covered) begin
                    tcur_reg <= tcur_reg + LEN_W'(1);
                end
            end
            mwmc_pkg::OP_HEAD_UPD: begin
                if (!drop) begin
                    hcur_reg <= hcur_reg + LEN_W'(1);
                end
            end
            mwmc_pkg::OP_BEST: begin
                if (improved) begin
                    best_len_reg   <= diff;
                    best_start_reg <= POS_W'(hcur_reg);
                    best_end_reg   <= POS_W'(tcur_reg);
                end
                tcur_reg <= tcur_reg + LEN_W'(1);
                hcur_reg <= hcur_reg + LEN_W'(1);
            end
            mwmc_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    m_found_reg <= found_reg;
                    m_start_reg <= found_reg ? best_start_reg : '0;
                    m_end_reg   <= found_reg ? best_end_reg : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {m_end_reg, m_start_reg};

endmodule

### sv/minimum_window_multiset_cover_top.sv
// ----------------------------------------------------------------------------
// minimum_window_multiset_cover_top: shortest window covering a pattern
// Loads pattern symbols and text symbols, then on a compute transaction scans
// the text with a head and a tail pointer and returns the shortest window
// that holds every pattern symbol at least as often as the pattern does.
//
//   Channel   Direction  Payload
//   s_*       in         tuser: opcode[1:0]; tdata: symbol[5:0], zero pad
//   m_*       out        tuser: found; tdata: window_start[11:0],
//                        window_end[23:12]
//
// A pattern load passes the dispatch, count read and count write steps before
// the next ready, and a text append the dispatch and append steps. In a
// compute each pointer step goes through the registered text read and the
// registered count table read of the microcode program, and each candidate
// window passes a best check.
// Reset (aresetn low, synchronous) clears the program counter, lengths,
// counters and table valid bits; no clearing pass is needed.
// The result sits in an output register, so new transactions are taken while
// it waits; a compute only waits at the end if the previous result is unread.
// ----------------------------------------------------------------------------
module minimum_window_multiset_cover_top #(
    parameter int MAX_TEXT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol[5:0], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // window_start[11:0], window_end[23:12]
    output logic        m_tuser    // found
);

    mwmc_pkg::dp_op_t     op;
    mwmc_pkg::dp_status_t status;

    // Program sequencer.
    mwmc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .op       (op),
        .in_ready (s_tready)
    );

    // Datapath with the text store and count tables.
    mwmc_dp #(
        .MAX_TEXT (MAX_TEXT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .status   (status)
    );

endmodule

### tb/minimum_window_multiset_cover_top_test.sv
// ----------------------------------------------------------------------------
// minimum_window_multiset_cover_top_test: self-checking bench for the window cover
// A table of directed transactions covers reset, an empty pattern, ignored symbols
// and opcodes, text overflow and pattern count saturation. Random pattern and text
// runs with compute transactions follow. Results are checked against a cycle-free
// model of the shortest covering window or, in four directed rows, a fixed value,
// with random stalls on both channels and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module minimum_window_multiset_cover_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPC_W          = mwmc_pkg::OPC_W;
    localparam int SYM_W          = mwmc_pkg::SYM_W;
    localparam int POS_OUT_W      = mwmc_pkg::POS_OUT_W;
    localparam int ALPHABET       = mwmc_pkg::ALPHABET;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int TEXT_CAP       = 4096;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int NUM_ROWS       = 25;

    // Opcode 3 has no enum member; the block ignores it.
    localparam logic [OPC_W-1:0] OPC_UNUSED = 2'd3;

    // One result: fields in the order of m_tuser and m_tdata.
    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] w_end;
        logic [POS_OUT_W-1:0] w_start;
    } cover_t;

    // One row of the directed table; a row repeats its transaction reps times.
    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic [SYM_W-1:0] sym;
        logic [13:0]      reps;
        logic             fixed;
        cover_t           want;
    } stim_row_t;

    localparam cover_t NO_COVER       = '0;
    localparam cover_t TAIL_END_COVER = '{1'b1, 12'd4095, 12'd4095};

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{mwmc_pkg::OPC_COMPUTE, 6'd0,  14'd1,    1'b1, NO_COVER},  // right after reset
        '{mwmc_pkg::OPC_APPEND,  6'd0,  14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_APPEND,  6'd51, 14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_COMPUTE, 6'd0,  14'd1,    1'b1, NO_COVER},  // empty pattern
        '{mwmc_pkg::OPC_LOAD,    6'd0,  14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_LOAD,    6'd51, 14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_LOAD,    6'd52, 14'd1,    1'b0, NO_COVER},  // out of range
        '{mwmc_pkg::OPC_APPEND,  6'd51, 14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_APPEND,  6'd63, 14'd1,    1'b0, NO_COVER},  // out of range
        '{mwmc_pkg::OPC_APPEND,  6'd0,  14'd2,    1'b0, NO_COVER},
        '{OPC_UNUSED,            6'd42, 14'd1,    1'b0, NO_COVER},  // ignored opcode
        '{mwmc_pkg::OPC_APPEND,  6'd51, 14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_COMPUTE, 6'd21, 14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_LOAD,    6'd26, 14'd2,    1'b0, NO_COVER},  // repeated symbol
        '{mwmc_pkg::OPC_APPEND,  6'd26, 14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_APPEND,  6'd1,  14'd2,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_APPEND,  6'd26, 14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_COMPUTE, 6'd0,  14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_LOAD,    6'd12, 14'd1,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_APPEND,  6'd3,  14'd4095, 1'b0, NO_COVER},
        '{mwmc_pkg::OPC_APPEND,  6'd12, 14'd3,    1'b0, NO_COVER},  // last two dropped
        '{mwmc_pkg::OPC_COMPUTE, 6'd0,  14'd1,    1'b1, TAIL_END_COVER},
        '{mwmc_pkg::OPC_LOAD,    6'd7,  14'd8193, 1'b0, NO_COVER},  // counts saturate
        '{mwmc_pkg::OPC_APPEND,  6'd7,  14'd3,    1'b0, NO_COVER},
        '{mwmc_pkg::OPC_COMPUTE, 6'd0,  14'd1,    1'b1, NO_COVER}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    // Model state: pattern counts, pattern length and the stored text.
    int unsigned      need_tbl [ALPHABET];
    int unsigned      pat_total;
    logic [SYM_W-1:0] text_q [$];

    cover_t pending_covers [$];
    int     items_sent    = 0;
    int     mismatch_count = 0;
    int     idle_cycles   = 0;
    bit     rx_long_hold  = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    minimum_window_multiset_cover_top #(
        .MAX_TEXT (TEXT_CAP)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Two-pointer scan over the stored text. The tail grows until every
    // pattern symbol is met, then the head moves until one falls short.
    // Only a strictly shorter window replaces the best one.
    function automatic cover_t shortest_cover();
        int unsigned have_tbl [ALPHABET];
        int unsigned distinct;
        int unsigned met;
        int          n, tail, head, best_len, t, h;
        bit          covered;
        cover_t      res;
        res = '0;
        distinct = 0;
        met = 0;
        for (int s = 0; s < ALPHABET; s++) begin
            have_tbl[s] = 0;
            if (need_tbl[s] != 0) distinct++;
        end
        if (distinct == 0) return res;
        n = text_q.size();
        best_len = n;
        tail = -1;
        head = -1;
        forever begin
            t = tail + 1;
            covered = 1'b0;
            while (t < n) begin
                have_tbl[text_q[t]]++;
                if (have_tbl[text_q[t]] == need_tbl[text_q[t]]) begin
                    met++;
                    if (met == distinct) begin
                        covered = 1'b1;
                        break;
                    end
                end
                t++;
            end
            if (!covered) break;
            tail = t;
            h = head + 1;
            while (h < n) begin
                if (have_tbl[text_q[h]] != 0) begin
                    have_tbl[text_q[h]]--;
                    if (have_tbl[text_q[h]] + 1 == need_tbl[text_q[h]]) begin
                        met--;
                        break;
                    end
                end
                h++;
            end
            head = h;
            if (tail - head < best_len) begin
                best_len = tail - head;
                res.found = 1'b1;
                res.w_start = POS_OUT_W'(head);
                res.w_end = POS_OUT_W'(tail);
                if (best_len + 1 == pat_total) break;
            end
        end
        return res;
    endfunction

    // Applies one accepted transaction to the model; returns 1 on a result.
    function automatic bit apply_item(input logic [OPC_W-1:0] op,
                                      input logic [SYM_W-1:0] sym,
                                      output cover_t res);
        res = '0;
        case (op)
            mwmc_pkg::OPC_LOAD: begin
                if (sym < ALPHABET) begin
                    if (need_tbl[sym] < mwmc_pkg::CNT_MAX) need_tbl[sym]++;
                    if (pat_total < mwmc_pkg::CNT_MAX) pat_total++;
                end
            end
            mwmc_pkg::OPC_APPEND: begin
                if (sym < ALPHABET && text_q.size() < TEXT_CAP) text_q.push_back(sym);
            end
            mwmc_pkg::OPC_COMPUTE: begin
                res = shortest_cover();
                foreach (need_tbl[s]) need_tbl[s] = 0;
                pat_total = 0;
                text_q.delete();
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic int pick_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 17);
    endfunction

    // Offers one transaction after a gap and waits for it to be taken.
    // Entered and left at a falling edge.
    task automatic send_item(input logic [OPC_W-1:0] op, input logic [SYM_W-1:0] sym,
                             input int gap, input bit use_fixed, input cover_t fixed_res);
        cover_t predicted;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, sym};
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (apply_item(op, sym, predicted))
            pending_covers.push_back(use_fixed ? fixed_res : predicted);
        if (op == mwmc_pkg::OPC_COMPUTE
            || ((op == mwmc_pkg::OPC_LOAD || op == mwmc_pkg::OPC_APPEND)
                && sym < ALPHABET))
            items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_covers.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One random run: mostly a pattern and a text over a narrow letter range
    // followed by a compute, sometimes plain noise.
    task automatic send_sequence(input bit burst);
        int               loads_left, appends_left, span, base;
        logic [OPC_W-1:0] op;
        logic [SYM_W-1:0] sym;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8))
                send_item(OPC_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 63)),
                          pick_gap(burst), 1'b0, NO_COVER);
            return;
        end
        span = $urandom_range(1, 6);
        base = $urandom_range(0, ALPHABET - span);
        loads_left = $urandom_range(1, 5);
        appends_left = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 120)
                                                   : $urandom_range(0, 30);
        while (loads_left + appends_left > 0) begin
            if (loads_left > 0 && (appends_left == 0 || $urandom_range(0, 2) == 0)) begin
                op = mwmc_pkg::OPC_LOAD;
                loads_left--;
            end else begin
                op = mwmc_pkg::OPC_APPEND;
                appends_left--;
            end
            sym = ($urandom_range(0, 11) == 0) ? SYM_W'($urandom_range(0, 63))
                                               : SYM_W'(base + $urandom_range(0, span - 1));
            send_item(op, sym, pick_gap(burst), 1'b0, NO_COVER);
        end
        send_item(mwmc_pkg::OPC_COMPUTE, SYM_W'($urandom_range(0, 63)), pick_gap(burst),
                  1'b0, NO_COVER);
    endtask

    // Sender: reset, directed table, random runs, then the final verdict.
    initial begin : stimulus
        int  random_start;
        int  seq_count;
        bit  mid_drained;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            repeat (DIRECTED_ROWS[r].reps)
                send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].sym, pick_gap(1'b0),
                          DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);
        end
        wait_results_drained();

        // The receiver holds off once early on while back-to-back runs arrive.
        rx_long_hold = 1'b1;
        random_start = items_sent;
        seq_count = 0;
        mid_drained = 1'b0;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            send_sequence(seq_count < 8 || $urandom_range(0, 4) == 0);
            seq_count++;
            if (!mid_drained && items_sent >= random_start + RANDOM_ITEMS / 2) begin
                wait_results_drained();
                mid_drained = 1'b1;
            end
        end
        wait_results_drained();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: a random stall before each result, with calm stretches and
    // one long hold on request.
    initial begin : receiver
        int stall;
        int calm_left;
        m_tready = 1'b0;
        calm_left = 0;
        @(negedge aclk);
        forever begin
            if (calm_left > 0) begin
                stall = 0;
                calm_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                stall = 0;
                calm_left = $urandom_range(5, 20);
            end else begin
                stall = $urandom_range(0, 17);
            end
            if (rx_long_hold) begin
                stall = stall + RX_HOLD_CYCLES;
                rx_long_hold = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            @(negedge aclk);
        end
    end

    // Result checker: each result transaction against the oldest expectation.
    always @(posedge aclk) begin : check_results
        cover_t want;
        cover_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{found: m_tuser, w_end: m_tdata[23:12], w_start: m_tdata[11:0]};
            if (pending_covers.size() == 0) begin
                $display("%0t: unexpected result, expected none, got found %0d start %0d end %0d",
                         $time, got.found, got.w_start, got.w_end);
                mismatch_count++;
            end else begin
                want = pending_covers.pop_front();
                if (got.found !== want.found) begin
                    $display("%0t: found mismatch, expected %0d, got %0d",
                             $time, want.found, got.found);
                    mismatch_count++;
                end
                if (got.w_start !== want.w_start) begin
                    $display("%0t: window_start mismatch, expected %0d, got %0d",
                             $time, want.w_start, got.w_start);
                    mismatch_count++;
                end
                if (got.w_end !== want.w_end) begin
                    $display("%0t: window_end mismatch, expected %0d, got %0d",
                             $time, want.w_end, got.w_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

### sim.f
sv/mwmc_pkg.sv
sv/mwmc_seq.sv
sv/mwmc_dp.sv
sv/minimum_window_multiset_cover_top.sv
tb/minimum_window_multiset_cover_top_test.sv
